### rtl/sha256_pkg.sv
package sha256_pkg;

  localparam int WordW = 32;
  localparam int ModeW = 2;

  typedef logic [WordW-1:0] word_t;

  // Digest modes.
  localparam logic [ModeW-1:0] ModeSha256 = 2'd0;
  localparam logic [ModeW-1:0] ModeSha224 = 2'd1;
  localparam logic [ModeW-1:0] ModeSha192 = 2'd2;

  // Entry handed from the front to the back.
  typedef struct packed {
    word_t word;
    logic  start;
    logic  fin;
  } entry_t;

  localparam int EntryW = WordW + 2;
  localparam int QueueDepth = 4;

  typedef enum logic [1:0] {
    BkIdle,
    BkRound,
    BkAdd,
    BkEmit
  } bk_state_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
      6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
      6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
      6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7; default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

  function automatic word_t iv_word(input logic sha224, input logic [2:0] i);
    word_t v;
    case (i)
      3'd0: v = sha224 ? 32'hC1059ED8 : 32'h6A09E667;
      3'd1: v = sha224 ? 32'h367CD507 : 32'hBB67AE85;
      3'd2: v = sha224 ? 32'h3070DD17 : 32'h3C6EF372;
      3'd3: v = sha224 ? 32'hF70E5939 : 32'hA54FF53A;
      3'd4: v = sha224 ? 32'hFFC00B31 : 32'h510E527F;
      3'd5: v = sha224 ? 32'h68581511 : 32'h9B05688C;
      3'd6: v = sha224 ? 32'h64F98FA7 : 32'h1F83D9AB;
      default: v = sha224 ? 32'hBEFA4FA4 : 32'h5BE0CD19;
    endcase
    return v;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

### rtl/sha256_queue.sv
module sha256_queue #(
  parameter int Width = sha256_pkg::EntryW,
  parameter int Depth = sha256_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [Width-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [Width-1:0] rd_data,
  output logic             empty
);
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem [Depth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [AddrW:0]   count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AddrW+1)'(Depth));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage is written only; the head is read at its pointer.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AddrW+1)'(do_wr) - (AddrW+1)'(do_rd);
    end
  end
endmodule

### rtl/sha256_front.sv
module sha256_front (
  input  logic                clk,
  input  logic                rst,
  input  sha256_pkg::word_t   message_word,
  input  logic                start_message,
  input  logic                end_message,
  input  logic                push,
  output logic                full,
  output sha256_pkg::entry_t  q_data,
  output logic                q_wr,
  input  logic                q_full
);
  import sha256_pkg::*;

  // The front takes a word whenever the queue has room and packs its flags.
  assign full   = q_full;
  assign q_wr   = push && !q_full;
  assign q_data = '{word: message_word, start: start_message, fin: end_message};

  logic unused;
  assign unused = clk ^ rst;
endmodule

### rtl/sha256_back.sv
module sha256_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sha256_pkg::ModeW-1:0] digest_mode,
  input  sha256_pkg::entry_t          q_data,
  input  logic                        q_empty,
  output logic                        q_rd,
  output sha256_pkg::word_t           digest_word,
  output logic                        last_word,
  output logic                        empty,
  input  logic                        pop,
  output logic                        busy
);
  import sha256_pkg::*;

  bk_state_t   state;
  bk_state_t   state_next;
  word_t       hash_state [8];
  word_t       v [8];
  word_t       w [16];
  logic [3:0]  word_count;
  logic [5:0]  round_count;
  logic        emit_after;
  logic [2:0]  emit_idx;
  logic [2:0]  emit_last;
  logic        out_valid;

  word_t       cur_w;
  word_t       s0;
  word_t       s1;
  word_t       t1;
  word_t       t2;
  logic        take;
  logic        full_block;
  logic [3:0]  wc_base;
  logic        sha224;
  logic        out_free;
  logic [3:0]  w15_idx;
  logic [3:0]  w7_idx;
  logic [3:0]  w2_idx;

  assign sha224   = (digest_mode == ModeSha224);
  assign out_free = !out_valid || pop;
  assign take     = (state == BkIdle) && !q_empty;
  assign q_rd     = take;
  assign wc_base  = q_data.start ? 4'd0 : word_count;
  assign full_block = (wc_base == 4'd15);
  assign busy     = (state != BkIdle) || out_valid;

  // Window positions of the older schedule words, modulo 16.
  assign w15_idx = round_count[3:0] - 4'd15;
  assign w7_idx  = round_count[3:0] - 4'd7;
  assign w2_idx  = round_count[3:0] - 4'd2;

  // Message schedule and round function.
  always_comb begin
    s0 = rotr(w[w15_idx], 7) ^ rotr(w[w15_idx], 18) ^ (w[w15_idx] >> 3);
    s1 = rotr(w[w2_idx], 17) ^ rotr(w[w2_idx], 19) ^ (w[w2_idx] >> 10);
    if (round_count < 6'd16) begin
      cur_w = w[round_count[3:0]];
    end else begin
      cur_w = w[round_count[3:0]] + s0 + w[w7_idx] + s1;
    end
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round_count) + cur_w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BkIdle: begin
        if (take) begin
          if (full_block) state_next = BkRound;
          else if (q_data.fin) state_next = BkEmit;
        end
      end
      BkRound: begin
        if (round_count == 6'd63) state_next = BkAdd;
      end
      BkAdd: begin
        state_next = emit_after ? BkEmit : BkIdle;
      end
      BkEmit: begin
        if (out_free && emit_idx == emit_last) state_next = BkIdle;
      end
      default: state_next = BkIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BkIdle;
    end else begin
      state <= state_next;
    end
  end

  // Schedule window is payload; written on load and during rounds.
  always_ff @(posedge clk) begin
    if (take) begin
      w[wc_base] <= q_data.word;
    end else if (state == BkRound && round_count >= 6'd16) begin
      w[round_count[3:0]] <= cur_w;
    end
  end

  // Chaining state, working variables, counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        hash_state[i] <= iv_word(1'b0, 3'(i));
        v[i]          <= '0;
      end
      word_count  <= '0;
      round_count <= '0;
      emit_after  <= 1'b0;
      emit_idx    <= '0;
      emit_last   <= 3'd7;
      out_valid   <= 1'b0;
      digest_word <= '0;
      last_word   <= 1'b0;
    end else begin
      // The output register fills while emitting and clears when taken.
      out_valid <= (state == BkEmit && out_free) || (out_valid && !pop);
      case (state)
        BkIdle: begin
          if (take) begin
            if (q_data.start) begin
              for (int i = 0; i < 8; i++) hash_state[i] <= iv_word(sha224, 3'(i));
            end
            word_count <= q_data.fin ? 4'd0 : wc_base + 4'd1;
            emit_after <= q_data.fin;
            emit_idx   <= '0;
            emit_last  <= (digest_mode == ModeSha224) ? 3'd6 :
                          (digest_mode == ModeSha192) ? 3'd5 : 3'd7;
            if (full_block) begin
              for (int i = 0; i < 8; i++) begin
                v[i] <= q_data.start ? iv_word(sha224, 3'(i)) : hash_state[i];
              end
            end
          end
        end
        BkRound: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round_count <= round_count + 6'd1;
        end
        BkAdd: begin
          for (int i = 0; i < 8; i++) hash_state[i] <= hash_state[i] + v[i];
        end
        BkEmit: begin
          if (out_free) begin
            digest_word <= hash_state[emit_idx];
            last_word   <= (emit_idx == emit_last);
            emit_idx    <= emit_idx + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign empty = !out_valid;
endmodule

### rtl/sha256_hash_core.sv
// SHA-256 / SHA-224 / SHA-256/192 compression engine.
// Input channel: a word (message_word with start_message, end_message) is
// taken at a clock edge with push high and full low. Words are padded,
// big-endian, 16 to a block; start_message loads the initial values first.
// Result channel: while empty is low, digest_word and last_word hold the
// oldest digest word; pop takes it. After end_message 8, 7 or 6 words follow
// depending on digest_mode, the last one marked by last_word.
// Configuration: digest_mode is written with cfg_valid and cfg_ready; cfg_ready
// is high only while the engine is idle.
// Flow: a front stage feeds a four-entry word queue. The back end takes a
// word while idle; on a full block it runs the 64 rounds and then the add
// step on the single round unit and takes no new word until that is done.
// Digest words come one per cycle, while the receiver pops, from a single
// output register, loaded in the emit state that ends each message.
// A stalled receiver holds the output register and stalls the back end; the
// queue then fills and full rises. Reset is synchronous; it empties the queue,
// loads the SHA-256 initial values and sets digest_mode to SHA-256.
module sha256_hash_core #(
  parameter int QueueDepth = sha256_pkg::QueueDepth
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sha256_pkg::word_t            message_word,
  input  logic                         start_message,
  input  logic                         end_message,
  input  logic                         push,
  output logic                         full,
  output sha256_pkg::word_t            digest_word,
  output logic                         last_word,
  output logic                         empty,
  input  logic                         pop,
  input  logic [sha256_pkg::ModeW-1:0] cfg_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready
);
  import sha256_pkg::*;

  logic [ModeW-1:0] digest_mode;
  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             q_wr;
  logic             q_full;
  logic             q_rd;
  logic             q_empty;
  logic             busy;

  // Mode register.
  assign cfg_ready = !busy && q_empty;
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_mode <= ModeSha256;
    end else if (cfg_valid && cfg_ready) begin
      digest_mode <= cfg_data;
    end
  end

  sha256_front u_front (
    .clk, .rst, .message_word, .start_message, .end_message, .push, .full,
    .q_data(wr_entry), .q_wr, .q_full
  );

  sha256_queue #(.Width(EntryW), .Depth(QueueDepth)) u_queue (
    .clk, .rst, .wr_en(q_wr), .wr_data(wr_entry), .full(q_full),
    .rd_en(q_rd), .rd_data(rd_entry), .empty(q_empty)
  );

  sha256_back u_back (
    .clk, .rst, .digest_mode, .q_data(rd_entry), .q_empty, .q_rd,
    .digest_word, .last_word, .empty, .pop, .busy
  );

`ifndef SYNTHESIS
  // A result held by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(last_word)))
    else $error("digest word changed while stalled");
  // Configuration is only taken while nothing is in flight.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> (empty && q_empty))
    else $error("mode written while busy");
  // The queue never overflows.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !q_wr)
    else $error("write into full queue");
`endif
endmodule

### verif/sha256_hash_core_tb.sv
module sha256_hash_core_tb;
  import sha256_pkg::*;

  // One accepted message word with its framing flags.
  typedef struct {
    word_t word;
    logic  start;
    logic  fin;
  } msg_word_t;

  // One digest word as it leaves the block.
  typedef struct {
    word_t word;
    logic  last;
  } digest_out_t;

  // One row of the directed table; has_digest marks a typed-in first word.
  typedef struct {
    word_t word;
    logic  start;
    logic  fin;
    logic  has_digest;
    word_t digest0;
  } dir_row_t;

  localparam int DirRows = 22;

  logic clk = 1'b0;
  logic rst = 1'b1;
  word_t message_word = '0;
  logic start_message = 1'b0;
  logic end_message = 1'b0;
  logic push = 1'b0;
  logic full;
  word_t digest_word;
  logic last_word;
  logic empty;
  logic pop = 1'b0;
  logic [ModeW-1:0] cfg_data = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;

  // Predictor state.
  logic [ModeW-1:0] pred_mode;
  word_t pred_hash[8];
  word_t pred_sched[16];
  logic [3:0] pred_count;

  digest_out_t digest_fifo[$];
  int errors = 0;
  int hold_off = 0;
  bit stim_done = 1'b0;
  dir_row_t dir_table[DirRows];

  sha256_hash_core u_dut (
    .clk(clk), .rst(rst),
    .message_word(message_word), .start_message(start_message),
    .end_message(end_message), .push(push), .full(full),
    .digest_word(digest_word), .last_word(last_word), .empty(empty), .pop(pop),
    .cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t ror(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Round constants, written out here so the predictor stands on its own.
  function automatic word_t kconst(int t);
    word_t k[64] = '{
      32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B,
      32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01,
      32'h243185BE, 32'h550C7DC3, 32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7,
      32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
      32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA, 32'h983E5152,
      32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
      32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC,
      32'h53380D13, 32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
      32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3, 32'hD192E819,
      32'hD6990624, 32'hF40E3585, 32'h106AA070, 32'h19A4C116, 32'h1E376C08,
      32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F,
      32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
      32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
    return k[t];
  endfunction

  function automatic word_t init_value(logic sha224, int i);
    word_t v256[8] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
                       32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
    word_t v224[8] = '{32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
                       32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4};
    return sha224 ? v224[i] : v256[i];
  endfunction

  // Runs the 64 rounds on the current window and adds into the hash state.
  task automatic compress();
    word_t v[8];
    word_t w, s0, s1, t1, t2, x;
    for (int i = 0; i < 8; i++) v[i] = pred_hash[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = pred_sched[t];
      end else begin
        x = pred_sched[(t - 15) & 15];
        s0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
        x = pred_sched[(t - 2) & 15];
        s1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
        w = pred_sched[t & 15] + s0 + pred_sched[(t - 7) & 15] + s1;
        pred_sched[t & 15] = w;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) pred_hash[i] = pred_hash[i] + v[i];
  endtask

  // Predicts the digest words caused by one accepted message word.
  task automatic predict_word(msg_word_t m);
    digest_out_t d;
    int n;
    if (m.start) begin
      for (int i = 0; i < 8; i++) pred_hash[i] = init_value(pred_mode == ModeSha224, i);
      pred_count = '0;
    end
    pred_sched[pred_count] = m.word;
    pred_count = pred_count + 4'd1;
    if (pred_count == 4'd0) compress();
    if (m.fin) begin
      pred_count = '0;
      n = (pred_mode == ModeSha224) ? 7 : (pred_mode == ModeSha192) ? 6 : 8;
      for (int k = 0; k < n; k++) begin
        d.word = pred_hash[k];
        d.last = (k == n - 1);
        digest_fifo.push_back(d);
      end
    end
  endtask

  // Offers one word and waits for it to be taken, then predicts it.
  task automatic send_word(msg_word_t m);
    push <= 1'b1;
    message_word <= m.word;
    start_message <= m.start;
    end_message <= m.fin;
    do @(posedge clk); while (full);
    predict_word(m);
  endtask

  // Sends one word; words go in bursts with random gaps in between.
  int burst_left = 0;
  task automatic offer(msg_word_t m);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_word(m);
  endtask

  // The last word was taken at this edge, so push drops before the next one.
  task automatic drain_and_idle();
    push <= 1'b0;
    @(posedge clk);
    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_mode(logic [ModeW-1:0] m);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_mode = m;
  endtask

  // Digest word checker against the predictor.
  always @(posedge clk) begin
    digest_out_t e;
    if (!rst && pop && !empty) begin
      if (digest_fifo.size() == 0) begin
        $error("digest word 0x%08h with no expectation", digest_word);
        errors++;
      end else begin
        e = digest_fifo.pop_front();
        if (digest_word !== e.word) begin
          $error("digest_word expected 0x%08h actual 0x%08h", e.word, digest_word);
          errors++;
        end
        if (last_word !== e.last) begin
          $error("last_word expected %0d actual %0d", e.last, last_word);
          errors++;
        end
      end
    end
  end

  // Receiver: its own stall pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 3) != 0) || stim_done;
    end
  end

  // Directed table: the first rows carry the known digest of the empty message.
  initial begin
    dir_table[0] = '{32'h80000000, 1'b1, 1'b0, 1'b0, '0};
    for (int i = 1; i < 15; i++) dir_table[i] = '{32'h0, 1'b0, 1'b0, 1'b0, '0};
    dir_table[15] = '{32'h0, 1'b0, 1'b1, 1'b1, 32'hE3B0C442};
    // Words chaining without start, ending inside a block.
    dir_table[16] = '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, '0};
    dir_table[17] = '{32'h00000000, 1'b0, 1'b1, 1'b0, '0};
    // Start and end on the same word, and extremes of the word.
    dir_table[18] = '{32'hFFFFFFFF, 1'b1, 1'b1, 1'b1, 32'h6A09E667};
    dir_table[19] = '{32'hAAAAAAAA, 1'b0, 1'b1, 1'b0, '0};
    dir_table[20] = '{32'h55555555, 1'b1, 1'b0, 1'b0, '0};
    dir_table[21] = '{32'h00000001, 1'b0, 1'b1, 1'b0, '0};
  end

  // Typed-in first digest words are checked against the predictor's output.
  task automatic check_typed(dir_row_t r);
    if (r.has_digest && digest_fifo.size() >= 8 &&
        digest_fifo[digest_fifo.size() - 8].word !== r.digest0) begin
      $error("digest_word expected 0x%08h actual 0x%08h (predictor)",
             r.digest0, digest_fifo[digest_fifo.size() - 8].word);
      errors++;
    end
  endtask

  // Random message: mostly whole blocks of random words, sometimes cut short or noisy.
  task automatic random_message(inout int sent);
    int nblk, len;
    msg_word_t m;
    nblk = $urandom_range(1, 2);
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16 * nblk) : 16 * nblk;
    for (int i = 0; i < len; i++) begin
      m.word = $urandom();
      if ($urandom_range(0, 7) == 0) m.word = ($urandom_range(0, 1) != 0) ? '1 : '0;
      m.start = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 40) == 0);
      m.fin = (i == len - 1);
      offer(m);
      sent++;
    end
  endtask

  initial begin
    int sent;
    logic [ModeW-1:0] modes[4] = '{ModeSha224, ModeSha192, 2'd3, ModeSha256};
    pred_mode = ModeSha256;
    for (int i = 0; i < 8; i++) pred_hash[i] = init_value(1'b0, i);
    for (int i = 0; i < 16; i++) pred_sched[i] = '0;
    pred_count = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part in SHA-256 mode.
    write_mode(ModeSha256);
    for (int i = 0; i < DirRows; i++) begin
      send_word('{dir_table[i].word, dir_table[i].start, dir_table[i].fin});
      check_typed(dir_table[i]);
    end
    drain_and_idle();

    // Random part, one phase per mode setting.
    sent = 0;
    foreach (modes[p]) begin
      write_mode(modes[p]);
      if (p == 0) hold_off = 400;
      while (sent < 40 * (p + 1)) random_message(sent);
      drain_and_idle();
    end

    stim_done = 1'b1;
    repeat (50) @(posedge clk);
    if (errors == 0 && digest_fifo.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sha256_hash_core.f
rtl/sha256_pkg.sv
rtl/sha256_queue.sv
rtl/sha256_front.sv
rtl/sha256_back.sv
rtl/sha256_hash_core.sv
verif/sha256_hash_core_tb.sv
